// ----- src/pwl_pkg.sv -----
// shared types and constants of the piecewise linear curve lookup unit
// no dependencies
package pwl_pkg;

  localparam int unsigned DefMaxPoints  = 256;
  localparam int unsigned DefMaxSamples = 4096;

  localparam logic [16:0] OneFix = 17'h10000;

  localparam int unsigned DivW   = 38;
  localparam int unsigned DvsW   = 18;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OP_DONE,
    OP_WRITE,
    OP_SAMPLE
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2,
    ST_INDEX = 2'd3
  } status_e;

  typedef struct packed {
    op_e         op;
    status_e     status;
    logic [7:0]  idx;
    logic [16:0] x;
    logic [16:0] y;
    logic [11:0] sidx;
  } item_t;

  typedef struct packed {
    logic [8:0]  point_count;
    logic [12:0] sample_count;
  } cfg_t;

endpackage

// ----- src/pwl_in_if.sv -----
// command channel of the curve lookup unit
// no dependencies
interface pwl_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  point_index;
  logic [16:0] x_coord;
  logic [16:0] y_coord;
  logic [11:0] sample_index;

  modport source(output valid, command, point_index, x_coord, y_coord, sample_index,
                 input ready);
  modport sink(input valid, command, point_index, x_coord, y_coord, sample_index,
               output ready);
endinterface

// ----- src/pwl_out_if.sv -----
// result channel of the curve lookup unit
// no dependencies
interface pwl_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] value;
  logic [1:0]  status;

  modport source(output valid, value, status, input ready);
  modport sink(input valid, value, status, output ready);
endinterface

// ----- src/pwl_front.sv -----
// front stage: accepts commands, checks index and range, classifies the item
// depends on pwl_pkg and pwl_in_if
module pwl_front #(
  parameter int unsigned MaxPoints  = pwl_pkg::DefMaxPoints,
  parameter int unsigned MaxSamples = pwl_pkg::DefMaxSamples
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pwl_in_if.sink         in_i,
  input  pwl_pkg::cfg_t  cfg_i,
  output pwl_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_ready_i
);

  localparam int unsigned NW = $clog2(MaxPoints + 1) + 1;

  logic           valid_q;
  pwl_pkg::item_t item_q, item_d;
  logic           accept;
  logic [12:0]    cnt;

  assign cnt    = cfg_i.sample_count;
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    item_d.idx    = in_i.point_index;
    item_d.x      = in_i.x_coord;
    item_d.y      = in_i.y_coord;
    item_d.sidx   = in_i.sample_index;
    item_d.op     = pwl_pkg::OP_DONE;
    item_d.status = pwl_pkg::ST_OK;
    if (!in_i.command) begin
      if (NW'(in_i.point_index) >= NW'(MaxPoints)) begin
        item_d.status = pwl_pkg::ST_INDEX;
      end else if (in_i.x_coord > pwl_pkg::OneFix || in_i.y_coord > pwl_pkg::OneFix) begin
        item_d.status = pwl_pkg::ST_RANGE;
      end else begin
        item_d.op = pwl_pkg::OP_WRITE;
      end
    end else begin
      if (cnt == 13'd0 || 32'(cnt) > 32'(MaxSamples) || {1'b0, in_i.sample_index} >= cnt) begin
        item_d.status = pwl_pkg::ST_INDEX;
      end else begin
        item_d.op = pwl_pkg::OP_SAMPLE;
      end
    end
  end

  assign in_i.ready   = !valid_q || item_ready_i;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- src/pwl_fifo.sv -----
// short queue between front and back stages
// depends on pwl_pkg
module pwl_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pwl_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output pwl_pkg::item_t item_o,
  output logic           valid_o
);

  localparam int unsigned PW = $clog2(pwl_pkg::QDepth);
  localparam int unsigned CW = $clog2(pwl_pkg::QDepth + 1);

  pwl_pkg::item_t slot_q [pwl_pkg::QDepth];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign ready_o = cnt_q != CW'(pwl_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(pwl_pkg::QDepth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(pwl_pkg::QDepth - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

// ----- src/pwl_div.sv -----
// serial restoring divider, one quotient bit per cycle
// depends on pwl_pkg
module pwl_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pwl_pkg::DivW-1:0]  dividend_i,
  input  logic [pwl_pkg::DvsW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [pwl_pkg::DivW-1:0]  quot_o
);

  localparam int unsigned DW = pwl_pkg::DivW;
  localparam int unsigned VW = pwl_pkg::DvsW;
  localparam int unsigned KW = $clog2(DW + 1);

  logic [KW-1:0] cnt_q;
  logic          done_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, dvs_q;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cnt_q == KW'(1);
      if (start_i) begin
        cnt_q <= KW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? VW'(shifted - {1'b0, dvs_q}) : VW'(shifted);
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

endmodule

// ----- src/pwl_back.sv -----
// back stage: point store, segment scan, interpolation, result register
// depends on pwl_pkg, pwl_out_if and pwl_div
module pwl_back #(
  parameter int unsigned MaxPoints = pwl_pkg::DefMaxPoints
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pwl_pkg::cfg_t  cfg_i,
  input  pwl_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  pwl_out_if.source      out_o
);

  localparam int unsigned AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned NW = (($clog2(MaxPoints + 1) > 9) ? $clog2(MaxPoints + 1) : 9) + 1;
  localparam int unsigned DW = pwl_pkg::DivW;
  localparam int unsigned VW = pwl_pkg::DvsW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WCMP  = 4'd1;
  localparam logic [3:0] S_XDIV  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_RD0   = 4'd5;
  localparam logic [3:0] S_RD1   = 4'd6;
  localparam logic [3:0] S_LAT1  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DIVST = 4'd9;
  localparam logic [3:0] S_QDIV  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [33:0]      mem_q [MaxPoints];
  logic [33:0]      rd_q;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [33:0]      wr_data;
  logic             wr_en;

  pwl_pkg::item_t   item_q;
  logic [16:0]      x_q, x0_q, y0_q, x1_q, y1_q, den_q;
  logic [AW-1:0]    seg_q;
  logic signed [35:0] prod_q;
  logic             neg_q;
  logic [16:0]      res_val_q;
  pwl_pkg::status_e res_st_q;
  logic             out_valid_q;
  logic [16:0]      out_val_q;
  pwl_pkg::status_e out_st_q;

  logic             div_start, div_done;
  logic [DW-1:0]    div_dvd, div_quo;
  logic [VW-1:0]    div_dvs;

  logic [NW-1:0]    n_clamp, np_ext;
  logic             scan_more, out_free;
  logic signed [17:0] dx, dy;
  logic signed [35:0] prod_d;
  logic signed [37:0] n2;
  logic [37:0]      mag;
  logic signed [39:0] qs, v;
  logic [16:0]      v_sat;
  logic [12:0]      cnt_m1;

  assign np_ext    = NW'(cfg_i.point_count);
  assign n_clamp   = (np_ext < NW'(2)) ? NW'(2) :
                     (np_ext > NW'(MaxPoints)) ? NW'(MaxPoints) : np_ext;
  assign scan_more = NW'(seg_q) + NW'(2) < n_clamp;
  assign out_free  = !out_valid_q || out_o.ready;
  assign cnt_m1    = cfg_i.sample_count - 13'd1;

  assign dx     = $signed({1'b0, x_q}) - $signed({1'b0, x0_q});
  assign dy     = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
  assign prod_d = dx * dy;
  assign n2     = $signed({prod_q[35], prod_q, 1'b0}) + $signed({21'd0, den_q});
  assign mag    = n2[37] ? (38'(-n2) + {20'd0, den_q, 1'b0} - 38'd1) : n2;
  assign qs     = $signed({2'b00, div_quo});
  assign v      = $signed({23'd0, y0_q}) + (neg_q ? -qs : qs);
  assign v_sat  = v[39] ? 17'd0 : (v > 40'sd65536) ? pwl_pkg::OneFix : v[16:0];

  always_comb begin
    state_d    = state_q;
    rd_addr    = AW'(seg_q) + AW'(1);
    wr_en      = 1'b0;
    wr_addr    = AW'(item_q.idx);
    wr_data    = {item_q.x, item_q.y};
    item_pop_o = 1'b0;
    div_start  = 1'b0;
    div_dvd    = DW'({item_i.sidx, 16'd0});
    div_dvs    = VW'(cnt_m1);
    unique case (state_q)
      S_IDLE: begin
        rd_addr = AW'(item_i.idx) - AW'(1);
        wr_addr = AW'(item_i.idx);
        wr_data = {item_i.x, item_i.y};
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          case (item_i.op)
            pwl_pkg::OP_WRITE: begin
              if (item_i.idx == 8'd0) begin
                wr_en   = 1'b1;
                state_d = S_OUT;
              end else begin
                state_d = S_WCMP;
              end
            end
            pwl_pkg::OP_SAMPLE: begin
              if (cfg_i.sample_count > 13'd1) begin
                div_start = 1'b1;
                state_d   = S_XDIV;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_WCMP: begin
        wr_en   = item_q.x > rd_q[33:17];
        state_d = S_OUT;
      end
      S_XDIV:  if (div_done) state_d = S_SCAN;
      S_SCAN:  state_d = scan_more ? S_SCMP : S_RD0;
      S_SCMP:  state_d = (x_q > rd_q[33:17]) ? S_SCAN : S_RD0;
      S_RD0: begin
        rd_addr = seg_q;
        state_d = S_RD1;
      end
      S_RD1:   state_d = S_LAT1;
      S_LAT1:  state_d = S_MUL;
      S_MUL:   state_d = (x1_q <= x0_q) ? S_OUT : S_DIVST;
      S_DIVST: begin
        div_start = 1'b1;
        div_dvd   = mag;
        div_dvs   = {den_q, 1'b0};
        state_d   = S_QDIV;
      end
      S_QDIV:  if (div_done) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        item_q    <= item_i;
        seg_q     <= '0;
        x_q       <= '0;
        res_val_q <= '0;
        res_st_q  <= item_i.status;
      end
      S_WCMP: begin
        if (item_q.x <= rd_q[33:17]) begin
          res_st_q <= pwl_pkg::ST_ORDER;
        end
      end
      S_XDIV: if (div_done) x_q <= div_quo[16:0];
      S_SCMP: if (x_q > rd_q[33:17]) seg_q <= seg_q + AW'(1);
      S_RD1: begin
        x0_q <= rd_q[33:17];
        y0_q <= rd_q[16:0];
      end
      S_LAT1: begin
        x1_q <= rd_q[33:17];
        y1_q <= rd_q[16:0];
      end
      S_MUL: prod_q <= prod_d;
      default: ;
    endcase
    if (state_q == S_MUL) begin
      if (rd_q[33:17] <= x0_q) begin
        res_val_q <= rd_q[16:0];
      end
      den_q <= rd_q[33:17] - x0_q;
    end
    if (state_q == S_DIVST) begin
      neg_q <= n2[37];
    end
    if (state_q == S_QDIV && div_done) begin
      res_val_q <= v_sat;
    end
    if (state_q == S_OUT && out_free) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
    end
  end

  pwl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quo)
  );

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_val_q;
  assign out_o.status = out_st_q;

  ap_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_data[33:17] <= pwl_pkg::OneFix && wr_data[16:0] <= pwl_pkg::OneFix))
    else $error("point stored out of range");

  ap_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XDIV && div_done) |-> div_quo <= DW'(pwl_pkg::OneFix))
    else $error("sample position above one");

  ap_value_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_val_q <= pwl_pkg::OneFix)
    else $error("value not saturated");

  ap_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q != pwl_pkg::ST_OK) |-> out_val_q == 17'd0)
    else $error("error result carries a value");

  ap_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QDIV && div_done) |=> state_q == S_OUT)
    else $error("interpolation result dropped");

endmodule

// ----- src/piecewise_linear_curve_lut_unit.sv -----
// top level of the piecewise linear curve lookup unit
// depends on pwl_pkg, pwl_in_if, pwl_out_if, pwl_front, pwl_fifo, pwl_back
//
// in_i carries commands: a write stores one control point (x, y) in its slot,
// a sample evaluates the curve at x = sample_index / (sample_count - 1).
// out_o returns one result item per command, in order: value and status.
// the apb port writes the point count (address 0) and sample_count (address 4).
// an item is registered in the front stage and waits in a two entry queue.
// the back stage runs one item at a time; the duration of a sample is set
// by the serial divider for the sample position, the scan through the
// single read port of the point store, and the serial divider for the
// interpolation slope.
// the result sits in an output register; while the receiver stalls the back
// stage finishes its item and the front keeps accepting until the queue fills.
// reset clears the control state and loads point count 2 and sample_count 256;
// the point store is not cleared and must be written before it is sampled.
module piecewise_linear_curve_lut_unit #(
  parameter int unsigned MaxPoints  = pwl_pkg::DefMaxPoints,
  parameter int unsigned MaxSamples = pwl_pkg::DefMaxSamples
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pwl_in_if.sink      in_i,
  pwl_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pwl_pkg::cfg_t  cfg_q;
  pwl_pkg::item_t f_item, q_item;
  logic           f_valid, f_ready, q_valid, q_pop;
  logic           cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {19'd0, cfg_q.sample_count} : {23'd0, cfg_q.point_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_count  <= 9'd2;
      cfg_q.sample_count <= 13'd256;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        cfg_q.sample_count <= pwdata[12:0];
      end else begin
        cfg_q.point_count <= pwdata[8:0];
      end
    end
  end

  pwl_front #(
    .MaxPoints  (MaxPoints),
    .MaxSamples (MaxSamples)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready)
  );

  pwl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .item_i  (f_item),
    .ready_o (f_ready),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .valid_o (q_valid)
  );

  pwl_back #(
    .MaxPoints (MaxPoints)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_pop_o   (q_pop),
    .out_o        (out_o)
  );

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench of piecewise_linear_curve_lut_unit: writes curves, samples them
// and compares every result item with a scoreboard that models the unit
// depends on pwl_pkg, pwl_in_if, pwl_out_if and the unit itself
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit CMD_WRITE = 1'b0;
  localparam bit CMD_SAMPLE = 1'b1;
  localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;
  localparam logic [2:0] ADDR_SAMPLE_COUNT = 3'd4;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned ITEM_TARGET = 1050;

  class curve_scoreboard;
    typedef struct {
      logic [16:0]      value;
      pwl_pkg::status_e status;
    } result_t;

    result_t     pending_q[$];
    logic [16:0] px[pwl_pkg::DefMaxPoints];
    logic [16:0] py[pwl_pkg::DefMaxPoints];
    bit          stored[pwl_pkg::DefMaxPoints];
    logic [8:0]  point_count;
    logic [12:0] sample_count;
    int          errors;
    int          checked;
    int          nonzero_status;

    function new();
      point_count = 9'd2;
      sample_count = 13'd256;
    endfunction

    function logic [16:0] curve_at(longint pos);
      int     n;
      int     seg;
      longint x0, y0, x1, y1, num, den, a, b, q, v;
      n = point_count;
      if (n < 2) n = 2;
      if (n > pwl_pkg::DefMaxPoints) n = pwl_pkg::DefMaxPoints;
      seg = 0;
      while (seg + 1 < n - 1 && pos > px[seg+1]) seg++;
      x0 = px[seg];
      y0 = py[seg];
      x1 = px[seg+1];
      y1 = py[seg+1];
      if (x1 <= x0) begin
        v = y1;
      end else begin
        den = x1 - x0;
        num = (pos - x0) * (y1 - y0);
        a = 2 * num + den;
        b = 2 * den;
        if (a >= 0) q = a / b;
        else q = -((-a + b - 1) / b);
        v = y0 + q;
      end
      if (v < 0) v = 0;
      if (v > pwl_pkg::OneFix) v = pwl_pkg::OneFix;
      return v[16:0];
    endfunction

    function void note_item(bit cmd, logic [7:0] idx, logic [16:0] x, logic [16:0] y,
                            logic [11:0] sidx);
      result_t r;
      longint  pos;
      r.value = '0;
      r.status = pwl_pkg::ST_OK;
      if (cmd == CMD_WRITE) begin
        if (idx >= pwl_pkg::DefMaxPoints) begin
          r.status = pwl_pkg::ST_INDEX;
        end else if (x > pwl_pkg::OneFix || y > pwl_pkg::OneFix) begin
          r.status = pwl_pkg::ST_RANGE;
        end else if (idx > 0 && x <= px[idx-1]) begin
          r.status = pwl_pkg::ST_ORDER;
        end else begin
          px[idx] = x;
          py[idx] = y;
          stored[idx] = 1'b1;
        end
      end else begin
        if (sample_count == 0 || sample_count > pwl_pkg::DefMaxSamples ||
            sidx >= sample_count) begin
          r.status = pwl_pkg::ST_INDEX;
        end else begin
          pos = 0;
          if (sample_count > 1)
            pos = (longint'(sidx) * pwl_pkg::OneFix) / (sample_count - 1);
          r.value = curve_at(pos);
        end
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check(logic [16:0] value, logic [1:0] status);
      result_t r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected item value %0d status %0d", value, status));
      end else begin
        r = pending_q.pop_front();
        checked++;
        if (status != 2'b00) nonzero_status++;
        if (status !== r.status)
          report($sformatf("status %0d, expected %0d", status, r.status));
        if (value !== r.value)
          report($sformatf("value %0d, expected %0d", value, r.value));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pwl_in_if  in_bus();
  pwl_out_if out_bus();

  piecewise_linear_curve_lut_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  curve_scoreboard sb = new();
  int  items_sent;
  int  writes_sent;
  int  samples_sent;
  int  phases_run;
  int  hold_cycles;
  bit  steady;
  int  stall_count;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.command = CMD_WRITE;
    in_bus.point_index = '0;
    in_bus.x_coord = '0;
    in_bus.y_coord = '0;
    in_bus.sample_index = '0;
    out_bus.ready = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) sb.check(out_bus.value, out_bus.status);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without progress", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(int n, int cnt);
    reg_write(ADDR_POINT_COUNT, n);
    reg_write(ADDR_SAMPLE_COUNT, cnt);
    sb.point_count = n[8:0];
    sb.sample_count = cnt[12:0];
  endtask

  task automatic send(bit cmd, logic [7:0] idx, logic [16:0] x, logic [16:0] y,
                      logic [11:0] sidx);
    int gap;
    if (!steady && $urandom_range(99) < 17) begin
      gap = $urandom_range(1, 6);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.command <= cmd;
    in_bus.point_index <= idx;
    in_bus.x_coord <= x;
    in_bus.y_coord <= y;
    in_bus.sample_index <= sidx;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_item(cmd, idx, x, y, sidx);
    items_sent++;
    if (cmd == CMD_WRITE) writes_sent++;
    else samples_sent++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_point(logic [7:0] idx, logic [16:0] x, logic [16:0] y);
    send(CMD_WRITE, idx, x, y, 12'($urandom));
  endtask

  task automatic sample(logic [11:0] sidx);
    send(CMD_SAMPLE, 8'($urandom), 17'($urandom), 17'($urandom), sidx);
  endtask

  function automatic logic [16:0] bad_coord();
    return 17'($urandom_range(65537, 131071));
  endfunction

  // writes slots 0..n-1 with rising x, mixing in rejected writes
  task automatic build_curve(int n);
    int          step;
    logic [16:0] x;
    logic [16:0] y;
    step = 65536 / n;
    for (int k = 0; k < n; k++) begin
      x = 17'(k * step + $urandom_range(0, step - 1));
      if (k == n - 1 && $urandom_range(3) == 0) x = pwl_pkg::OneFix;
      if (k == 0 && $urandom_range(3) == 0) x = 0;
      y = $urandom_range(3) == 0 ? ($urandom_range(1) ? pwl_pkg::OneFix : 17'd0)
                                 : 17'($urandom_range(0, 65536));
      case ($urandom_range(9))
        0: write_point(8'(k), bad_coord(), y);
        1: write_point(8'(k), x, bad_coord());
        2: if (k > 0) write_point(8'(k), 17'($urandom_range(0, sb.px[k-1])), y);
        default: ;
      endcase
      write_point(8'(k), x, y);
    end
  endtask

  task automatic random_items(int count, int n, int cnt);
    int          k;
    logic [16:0] x;
    repeat (count) begin
      if ($urandom_range(99) < 80) begin
        if (cnt >= 1 && $urandom_range(9) != 0)
          sample(12'($urandom_range(0, (cnt > 4096 ? 4096 : cnt) - 1)));
        else
          sample(12'($urandom));
      end else begin
        k = $urandom_range(0, n - 1);
        if (k > 0 && sb.stored[k-1]) begin
          x = $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(sb.px[k-1], 65536));
        end else begin
          k = 0;
          x = 17'($urandom_range(0, sb.px[1]));
        end
        write_point(8'(k), x,
                    $urandom_range(4) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)));
      end
    end
  endtask

  task automatic run_phase(int n, int cnt, int count);
    int eff;
    eff = n < 2 ? 2 : (n > 256 ? 256 : n);
    wait_drained();
    configure(n, cnt);
    build_curve(eff);
    random_items(count, eff, cnt);
    phases_run++;
  endtask

  initial begin
    steady = 1'b0;
    hold_cycles = 0;
    stall_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(2, 256);
    write_point(0, 0, 0);
    write_point(1, pwl_pkg::OneFix, pwl_pkg::OneFix);
    write_point(1, 0, 5);
    write_point(0, 17'h1FFFF, 0);
    write_point(0, 0, 17'h1FFFF);
    sample(0);
    sample(255);
    sample(128);
    sample(256);
    sample(12'hFFF);
    write_point(0, pwl_pkg::OneFix, 100);
    sample(0);
    sample(200);
    write_point(0, 0, pwl_pkg::OneFix);
    write_point(1, 32768, 0);
    sample(255);
    sample(64);
    write_point(1, 1, pwl_pkg::OneFix);
    sample(100);
    write_point(0, 40000, 9000);
    sample(0);
    sample(255);
    phases_run++;

    run_phase(256, 4096, 30);
    sample(4095);
    write_point(255, pwl_pkg::OneFix, 1234);
    sample(4095);

    steady = 1'b1;
    run_phase(300, 4096, 25);
    steady = 1'b0;
    run_phase(0, 1, 30);
    run_phase(1, 0, 10);
    run_phase(5, 5000, 10);
    run_phase(3, 2, 30);

    wait_drained();
    configure(4, 64);
    build_curve(4);
    hold_cycles = 1500;
    random_items(30, 4, 64);
    phases_run++;

    while (items_sent < ITEM_TARGET) begin
      run_phase($urandom_range(3) == 0 ? $urandom_range(2, 64) : $urandom_range(2, 12),
                $urandom_range(3) == 0 ? $urandom_range(1, 8) : $urandom_range(1, 4096),
                $urandom_range(20, 70));
    end

    wait_drained();
    repeat (700) @(posedge clk_i);
    $display("%0d items (%0d point writes, %0d samples) over %0d register settings",
             items_sent, writes_sent, samples_sent, phases_run);
    $display("%0d results checked, %0d with error status, %0d mismatches",
             sb.checked, sb.nonzero_status, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
